// File: sv/uncommented_range_finder_defines.svh
// Assertion macros for the range finder checker.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef UNCOMMENTED_RANGE_FINDER_DEFINES_SVH
`define UNCOMMENTED_RANGE_FINDER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define URF_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("range finder check failed");

// Next-cycle implication, disabled during reset
`define URF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("range finder check failed");

`endif

// File: sv/urf_pkg.sv
// Package for the uncommented range finder: widths, characters, register map.
// Used by uncommented_range_finder and urf_checker; depends on nothing.
package urf_pkg;

    localparam int POS_BITS   = 24;
    localparam int FIELD_BITS = 24;
    localparam int CMP_BITS   = (POS_BITS > FIELD_BITS) ? POS_BITS : FIELD_BITS;
    localparam int ADDR_BITS  = 3;
    localparam int DATA_BITS  = 32;

    localparam logic [POS_BITS-1:0]   POS_MAX         = {POS_BITS{1'b1}};
    localparam logic [FIELD_BITS-1:0] MIN_WIDTH_RESET = FIELD_BITS'(17);

    // Characters of interest
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    // Register index (word address = paddr[ADDR_BITS-1:2])
    localparam logic [ADDR_BITS-3:0] REG_MIN_WIDTH = '0;

    typedef logic [POS_BITS-1:0]   pos_t;
    typedef logic [FIELD_BITS-1:0] field_t;

    // Result word: start in the low half, end in the high half
    typedef struct packed {
        field_t range_end;
        field_t range_start;
    } range_t;

    // Saturating increment of a position
    function automatic pos_t sat_inc(input pos_t v);
        return (v == POS_MAX) ? POS_MAX : v + POS_BITS'(1);
    endfunction

endpackage

// File: sv/uncommented_range_finder.sv
// Uncommented range finder: one byte per clock unless a result stalls; uses urf_pkg.
// A range appears on m_tvalid the cycle after the byte that closes it.
// It takes one byte per clock, the whole scan state being updated per byte;
// s_tready drops only while a held result is not taken.
// Reset (rst_n low, async): scan state cleared, range open at 0,
// min_range_width back to 17, no result pending.
module uncommented_range_finder
(
    input  logic        clk,
    input  logic        rst_n,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic        s_tlast,   // is_last
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [2*urf_pkg::FIELD_BITS-1:0] m_tdata, // [23:0] range_start, [47:24] range_end
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [urf_pkg::ADDR_BITS-1:0] paddr,
    input  logic [urf_pkg::DATA_BITS-1:0] pwdata,
    output logic [urf_pkg::DATA_BITS-1:0] prdata,
    output logic        pready
);

    // Scan state
    urf_pkg::pos_t   pos_reg, pos_next;
    urf_pkg::pos_t   start_reg, start_next;
    logic            open_reg, open_next;
    logic            slash_reg, slash_next;
    logic            inside_reg, inside_next;
    logic            block_reg, block_next;
    logic            star_reg, star_next;

    urf_pkg::field_t  min_width_reg;
    logic             out_valid_reg, out_valid_next;
    urf_pkg::range_t  out_data_reg, out_data_next;

    logic            accept;
    logic            cfg_write;
    logic            comment_open;
    logic            do_close;
    logic            close_open;
    urf_pkg::pos_t   close_start;
    urf_pkg::pos_t   close_end;
    urf_pkg::pos_t   end_clamped;
    urf_pkg::pos_t   pos_inc;
    urf_pkg::pos_t   pos_dec;
    urf_pkg::pos_t   range_width;
    logic            report;
    // State after the byte itself, before the end-of-file close
    urf_pkg::pos_t   mid_start;
    logic            mid_open;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = !out_valid_reg || m_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    // Register read
    always_comb
    begin
        prdata = '0;
        if (paddr[urf_pkg::ADDR_BITS-1:2] == urf_pkg::REG_MIN_WIDTH)
        begin
            prdata = urf_pkg::DATA_BITS'(min_width_reg);
        end
    end

    // Comment tracking for one byte
    always_comb
    begin
        pos_inc      = urf_pkg::sat_inc(pos_reg);
        pos_dec      = (pos_reg != '0) ? pos_reg - urf_pkg::POS_BITS'(1) : '0;
        slash_next   = slash_reg;
        inside_next  = inside_reg;
        block_next   = block_reg;
        star_next    = star_reg;
        mid_start    = start_reg;
        mid_open     = open_reg;
        comment_open = 1'b0;

        if (inside_reg)
        begin
            if (block_reg)
            begin
                if (star_reg && s_tdata == urf_pkg::CH_SLASH)
                begin
                    inside_next = 1'b0;
                    block_next  = 1'b0;
                    star_next   = 1'b0;
                    mid_start   = pos_inc;
                    mid_open    = 1'b1;
                end
                else
                begin
                    star_next = (s_tdata == urf_pkg::CH_STAR);
                end
            end
            else if (s_tdata == urf_pkg::CH_NEWLINE)
            begin
                inside_next = 1'b0;
                mid_start   = pos_inc;
                mid_open    = 1'b1;
            end
        end
        else if (slash_reg)
        begin
            slash_next = 1'b0;
            if (s_tdata == urf_pkg::CH_STAR || s_tdata == urf_pkg::CH_SLASH)
            begin
                inside_next  = 1'b1;
                block_next   = (s_tdata == urf_pkg::CH_STAR);
                star_next    = 1'b0;
                comment_open = 1'b1;
                mid_open     = 1'b0;
            end
        end
        else if (s_tdata == urf_pkg::CH_SLASH)
        begin
            slash_next = 1'b1;
        end
    end

    // Range close: at a comment opener, else at the last byte
    always_comb
    begin
        do_close    = comment_open || s_tlast;
        close_open  = comment_open ? open_reg  : mid_open;
        close_start = comment_open ? start_reg : mid_start;
        close_end   = comment_open ? pos_dec   : pos_inc;
        end_clamped = (close_end < close_start) ? close_start : close_end;
        range_width = end_clamped - close_start;
        report      = do_close && close_open &&
                      (urf_pkg::CMP_BITS'(range_width) >=
                       urf_pkg::CMP_BITS'(min_width_reg));
    end

    // Next state and result register
    always_comb
    begin
        pos_next       = pos_reg;
        start_next     = start_reg;
        open_next      = open_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (accept)
        begin
            out_valid_next = report;
            if (report)
            begin
                out_data_next.range_start = urf_pkg::FIELD_BITS'(close_start);
                out_data_next.range_end   = urf_pkg::FIELD_BITS'(end_clamped);
            end
            pos_next   = pos_inc;
            start_next = mid_start;
            open_next  = mid_open;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // State registers; the last byte rearms the scanner
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            start_reg     <= '0;
            open_reg      <= 1'b1;
            slash_reg     <= 1'b0;
            inside_reg    <= 1'b0;
            block_reg     <= 1'b0;
            star_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            min_width_reg <= urf_pkg::MIN_WIDTH_RESET;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept && s_tlast)
            begin
                pos_reg    <= '0;
                start_reg  <= '0;
                open_reg   <= 1'b1;
                slash_reg  <= 1'b0;
                inside_reg <= 1'b0;
                block_reg  <= 1'b0;
                star_reg   <= 1'b0;
            end
            else if (accept)
            begin
                pos_reg    <= pos_next;
                start_reg  <= start_next;
                open_reg   <= open_next;
                slash_reg  <= slash_next;
                inside_reg <= inside_next;
                block_reg  <= block_next;
                star_reg   <= star_next;
            end
            if (cfg_write && paddr[urf_pkg::ADDR_BITS-1:2] == urf_pkg::REG_MIN_WIDTH)
            begin
                min_width_reg <= pwdata[urf_pkg::FIELD_BITS-1:0];
            end
        end
    end

    // Result payload, no reset needed
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

endmodule

// File: sv/urf_checker.sv
// Port-level checks for the uncommented range finder, bound to the top level.
// Depends on urf_pkg and uncommented_range_finder_defines.svh.
`include "uncommented_range_finder_defines.svh"

module urf_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [2*urf_pkg::FIELD_BITS-1:0] m_tdata
);

    // A free result register always takes input
    `URF_ASSERT_NOW(a_ready_when_empty, !m_tvalid, s_tready)

    // Reported ranges never end before they start
    `URF_ASSERT_NOW(a_end_after_start, m_tvalid,
        m_tdata[2*urf_pkg::FIELD_BITS-1:urf_pkg::FIELD_BITS] >=
        m_tdata[urf_pkg::FIELD_BITS-1:0])

    // A stalled result stays put
    `URF_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid)
    `URF_ASSERT_NEXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata))

endmodule

bind uncommented_range_finder urf_checker u_urf_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
